/* hw/rtl/lno_pkg.sv */
// shared types, constants and trig tables for the nearest-obstacle search
package lno_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int ANGLE_STEPS = 720;
   localparam int QUARTER     = ANGLE_STEPS / 4;

   localparam int RANGE_W  = 16;
   localparam int POS_W    = $clog2(MAX_SAMPLES);
   localparam int WEND_W   = POS_W + 1;
   localparam int STEP_W   = $clog2(QUARTER);
   localparam int MAG_W    = 15;
   localparam int COORD_W  = 21;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SAMPLES - 1);

   localparam logic [RANGE_W-1:0] MIN_VALID_RESET   = 16'd100;
   localparam logic [RANGE_W-1:0] MAX_VALID_RESET   = 16'd30000;
   localparam logic [POS_W-1:0]   WINDOW_FIRST_RESET = '0;
   localparam logic [WEND_W-1:0]  WINDOW_END_RESET  = WEND_W'(720);
   localparam logic [RANGE_W-1:0] DETECT_LIMIT_RESET = 16'd3000;

   localparam logic signed [COORD_W-1:0] NOT_FOUND_MM = -21'sd1000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_VALID    = 3'd0,
      CSR_MAX_VALID    = 3'd1,
      CSR_WINDOW_FIRST = 3'd2,
      CSR_WINDOW_END   = 3'd3,
      CSR_DETECT_LIMIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [RANGE_W-1:0] min_valid_mm;
      logic [RANGE_W-1:0] max_valid_mm;
      logic [POS_W-1:0]   window_first;
      logic [WEND_W-1:0]  window_end;
      logic [RANGE_W-1:0] detect_limit_mm;
   } cfg_type;

   typedef struct packed {
      logic               found;
      logic [RANGE_W-1:0] range_mm;
      logic [POS_W-1:0]   pos;
   } scan_result_type;

   typedef struct packed {
      logic               found;
      logic [RANGE_W-1:0] range_mm;
      logic [POS_W-1:0]   pos;
      logic [1:0]         quad;
      logic [STEP_W-1:0]  step;
   } angle_type;

   typedef struct packed {
      logic               found;
      logic [RANGE_W-1:0] range_mm;
      logic [POS_W-1:0]   pos;
      logic [MAG_W-1:0]   sin_mag;
      logic               sin_neg;
      logic [MAG_W-1:0]   cos_mag;
      logic               cos_neg;
   } trig_type;

   typedef logic [QUARTER-1:0][MAG_W-1:0] trig_lut_type;

   typedef logic [12:0][9:0] term_div_type;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;

   // taylor term divisors, (2i)(2i+1) for sine and (2i-1)(2i) for cosine, first term lowest
   localparam term_div_type SIN_TERM_DIV = {10'd702, 10'd600, 10'd506, 10'd420, 10'd342,
      10'd272, 10'd210, 10'd156, 10'd110, 10'd72, 10'd42, 10'd20, 10'd6};
   localparam term_div_type COS_TERM_DIV = {10'd650, 10'd552, 10'd462, 10'd380, 10'd306,
      10'd240, 10'd182, 10'd132, 10'd90, 10'd56, 10'd30, 10'd12, 10'd2};

   // first-quadrant sine or cosine magnitudes in q0.15, from a q30 taylor sum
   function automatic trig_lut_type build_trig_lut(input logic want_cos);
      trig_lut_type      lut;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   ts;
      longint unsigned   tc;
      longint unsigned   sq;
      longint unsigned   cq;
      longint            s;
      longint            c;
      int                j;
      int                i;
      lut = '0;
      for (j = 0; j < QUARTER; j++) begin
         x  = (longint'(4 * j) * PI_HALF_Q30 + ANGLE_STEPS / 2) / ANGLE_STEPS;
         x2 = (x * x) >> 30;
         ts = x;
         tc = ONE_Q30;
         s  = longint'(x);
         c  = longint'(ONE_Q30);
         for (i = 1; i <= 13; i++) begin
            ts = ((ts * x2) >> 30) / SIN_TERM_DIV[i - 1];
            tc = ((tc * x2) >> 30) / COS_TERM_DIV[i - 1];
            if ((i % 2) == 1) begin
               s = s - longint'(ts);
               c = c - longint'(tc);
            end else begin
               s = s + longint'(ts);
               c = c + longint'(tc);
            end
         end
         if (s < 0) s = 0;
         if (c < 0) c = 0;
         if (s > longint'(ONE_Q30)) s = longint'(ONE_Q30);
         if (c > longint'(ONE_Q30)) c = longint'(ONE_Q30);
         sq = (longint'(s) + 16384) >> 15;
         cq = (longint'(c) + 16384) >> 15;
         if (sq > 32767) sq = 32767;
         if (cq > 32767) cq = 32767;
         lut[j] = want_cos ? cq[MAG_W-1:0] : sq[MAG_W-1:0];
      end
      return lut;
   endfunction

   localparam trig_lut_type SIN_LUT = build_trig_lut(1'b0);
   localparam trig_lut_type COS_LUT = build_trig_lut(1'b1);

endpackage

/* hw/rtl/lidar_nearest_obstacle.sv */
// top level of the nearest-obstacle search over a lidar scan
//
// req channel: one range sample per request, range in mm in req_tdata, and
// req_tlast on the final sample of the scan. samples are numbered from 0 in
// arrival order; the count holds at its top value on over-long scans.
// rsp channel: one request per scan, issued for the sample marked last,
// carrying the found flag in rsp_tuser and x, y and the angle index in
// rsp_tdata. nothing is issued for other samples.
// csr port: write-only; csr_index picks the register, csr_wdata is taken
// on any cycle with csr_we high. write only while no scan is in flight.
// throughput: one sample per cycle while req_tready is high. the result of
// a last sample passes the input register, minimum tracker, angle split,
// table lookup and the multiply into the result register.
// reset: registers return to their defaults and a new scan starts at 0.
// stalls: a held rsp_tready fills the pipeline; ordinary samples keep
// flowing through the tracker, and req_tready drops only when a last
// sample cannot move on.
module lidar_nearest_obstacle (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lno_pkg::REQ_DATA_W-1:0]      req_tdata,   // [15:0] range_mm
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [20:0] obstacle_x_mm, [41:21] obstacle_y_mm, [51:42] angle_index, [55:52] zero
   output logic [lno_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser,   // [0] found
   input  logic                                csr_we,
   input  logic [lno_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lno_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   lno_pkg::cfg_type           cfg_ff, cfg_in;
   logic                       res_valid;
   logic                       res_ready;
   lno_pkg::scan_result_type   res;
   logic                       trig_valid;
   logic                       trig_ready;
   lno_pkg::trig_type          trig;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lno_pkg::CSR_MIN_VALID:    cfg_in.min_valid_mm    = csr_wdata;
            lno_pkg::CSR_MAX_VALID:    cfg_in.max_valid_mm    = csr_wdata;
            lno_pkg::CSR_WINDOW_FIRST: cfg_in.window_first    = csr_wdata[lno_pkg::POS_W-1:0];
            lno_pkg::CSR_WINDOW_END:   cfg_in.window_end      = csr_wdata[lno_pkg::WEND_W-1:0];
            lno_pkg::CSR_DETECT_LIMIT: cfg_in.detect_limit_mm = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_valid_mm    <= lno_pkg::MIN_VALID_RESET;
         cfg_ff.max_valid_mm    <= lno_pkg::MAX_VALID_RESET;
         cfg_ff.window_first    <= lno_pkg::WINDOW_FIRST_RESET;
         cfg_ff.window_end      <= lno_pkg::WINDOW_END_RESET;
         cfg_ff.detect_limit_mm <= lno_pkg::DETECT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lno_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_range_mm (req_tdata[lno_pkg::RANGE_W-1:0]),
      .in_last     (req_tlast),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   lno_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_res    (res),
      .out_valid (trig_valid),
      .out_ready (trig_ready),
      .out_trig  (trig)
   );

   lno_coord u_coord (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (trig_valid),
      .in_ready   (trig_ready),
      .in_trig    (trig),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hw/rtl/lno_tracker.sv */
// input register, sample numbering and running minimum over one scan
module lno_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  lno_pkg::cfg_type                cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [lno_pkg::RANGE_W-1:0]     in_range_mm,
   input  logic                            in_last,
   output logic                            res_valid,
   input  logic                            res_ready,
   output lno_pkg::scan_result_type        res
);

   logic                          a_vld_ff, a_vld_in;
   logic [lno_pkg::RANGE_W-1:0]   a_range_ff, a_range_in;
   logic                          a_last_ff, a_last_in;
   logic                          b_vld_ff, b_vld_in;
   lno_pkg::scan_result_type      b_ff, b_in;

   logic [lno_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic                          have_ff, have_in;
   logic [lno_pkg::RANGE_W-1:0]   best_range_ff, best_range_in;
   logic [lno_pkg::POS_W-1:0]     best_pos_ff, best_pos_in;

   logic b_ready;
   logic a_take;
   logic cand;

   assign b_ready  = !b_vld_ff || res_ready;
   // a last sample waits here until the result stage has room
   assign a_take   = a_vld_ff && (!a_last_ff || b_ready);
   assign in_ready = !a_vld_ff || a_take;

   assign cand = (pos_ff >= cfg.window_first)
              && ({1'b0, pos_ff} < cfg.window_end)
              && (a_range_ff >= cfg.min_valid_mm)
              && (a_range_ff <= cfg.max_valid_mm)
              && (a_range_ff < cfg.detect_limit_mm)
              && (!have_ff || (a_range_ff < best_range_ff));

   always_comb begin
      a_vld_in   = a_vld_ff;
      a_range_in = a_range_ff;
      a_last_in  = a_last_ff;
      if (in_ready) begin
         a_vld_in = in_valid;
      end
      if (in_valid && in_ready) begin
         a_range_in = in_range_mm;
         a_last_in  = in_last;
      end

      pos_in        = pos_ff;
      have_in       = have_ff;
      best_range_in = best_range_ff;
      best_pos_in   = best_pos_ff;
      b_vld_in      = b_vld_ff && !res_ready;
      b_in          = b_ff;
      if (a_take) begin
         if (cand) begin
            have_in       = 1'b1;
            best_range_in = a_range_ff;
            best_pos_in   = pos_ff;
         end
         if (pos_ff != lno_pkg::POS_LAST) begin
            pos_in = pos_ff + 1'b1;
         end
         if (a_last_ff) begin
            b_vld_in       = 1'b1;
            b_in.found     = have_ff || cand;
            b_in.range_mm  = cand ? a_range_ff : best_range_ff;
            b_in.pos       = cand ? pos_ff : best_pos_ff;
            pos_in         = '0;
            have_in        = 1'b0;
            best_range_in  = cfg.detect_limit_mm;
            best_pos_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff      <= 1'b0;
         b_vld_ff      <= 1'b0;
         pos_ff        <= '0;
         have_ff       <= 1'b0;
         best_range_ff <= lno_pkg::DETECT_LIMIT_RESET;
         best_pos_ff   <= '0;
      end else begin
         a_vld_ff      <= a_vld_in;
         b_vld_ff      <= b_vld_in;
         pos_ff        <= pos_in;
         have_ff       <= have_in;
         best_range_ff <= best_range_in;
         best_pos_ff   <= best_pos_in;
      end
      a_range_ff <= a_range_in;
      a_last_ff  <= a_last_in;
      b_ff       <= b_in;
   end

   assign res_valid = b_vld_ff;
   assign res       = b_ff;

   a_scan_restart: assert property (@(posedge clock) disable iff (reset)
      a_take && a_last_ff |=> pos_ff == '0 && !have_ff)
      else $error("scan state not cleared after last sample");

   a_pos_count: assert property (@(posedge clock) disable iff (reset)
      a_take && !a_last_ff |=>
         pos_ff == $past(pos_ff) + 1'b1 || pos_ff == lno_pkg::POS_LAST)
      else $error("sample position did not advance");

   a_last_held: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff && a_last_ff && !b_ready |=> a_vld_ff && a_last_ff)
      else $error("stalled last sample dropped");

endmodule

/* hw/rtl/lno_trig.sv */
// angle split into quadrant and step, then sine and cosine table lookup
module lno_trig (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  lno_pkg::scan_result_type    in_res,
   output logic                        out_valid,
   input  logic                        out_ready,
   output lno_pkg::trig_type           out_trig
);

   localparam logic [lno_pkg::POS_W-1:0] K_WRAP = lno_pkg::POS_W'(lno_pkg::ANGLE_STEPS);
   localparam logic [lno_pkg::POS_W-1:0] K_Q1 = lno_pkg::POS_W'(lno_pkg::QUARTER);
   localparam logic [lno_pkg::POS_W-1:0] K_Q2 = lno_pkg::POS_W'(2 * lno_pkg::QUARTER);
   localparam logic [lno_pkg::POS_W-1:0] K_Q3 = lno_pkg::POS_W'(3 * lno_pkg::QUARTER);

   logic                   ang_vld_ff, ang_vld_in;
   lno_pkg::angle_type     ang_ff, ang_in;
   logic                   lut_vld_ff, lut_vld_in;
   lno_pkg::trig_type      lut_ff, lut_in;

   logic                          ang_ready;
   logic                          lut_ready;
   logic [lno_pkg::POS_W-1:0]     k;
   logic [lno_pkg::MAG_W-1:0]     sv;
   logic [lno_pkg::MAG_W-1:0]     cv;

   assign lut_ready = !lut_vld_ff || out_ready;
   assign ang_ready = !ang_vld_ff || lut_ready;
   assign in_ready  = ang_ready;

   // positions past one turn wrap back
   assign k = (in_res.pos >= K_WRAP) ? (in_res.pos - K_WRAP) : in_res.pos;

   assign sv = lno_pkg::SIN_LUT[ang_ff.step];
   assign cv = lno_pkg::COS_LUT[ang_ff.step];

   always_comb begin
      ang_vld_in = ang_ready ? in_valid : ang_vld_ff;
      ang_in     = ang_ff;
      if (in_valid && ang_ready) begin
         ang_in.found    = in_res.found;
         ang_in.range_mm = in_res.range_mm;
         ang_in.pos      = in_res.pos;
         if (k >= K_Q3) begin
            ang_in.quad = 2'd3;
            ang_in.step = lno_pkg::STEP_W'(k - K_Q3);
         end else if (k >= K_Q2) begin
            ang_in.quad = 2'd2;
            ang_in.step = lno_pkg::STEP_W'(k - K_Q2);
         end else if (k >= K_Q1) begin
            ang_in.quad = 2'd1;
            ang_in.step = lno_pkg::STEP_W'(k - K_Q1);
         end else begin
            ang_in.quad = 2'd0;
            ang_in.step = lno_pkg::STEP_W'(k);
         end
      end

      lut_vld_in = lut_ready ? ang_vld_ff : lut_vld_ff;
      lut_in     = lut_ff;
      if (ang_vld_ff && lut_ready) begin
         lut_in.found    = ang_ff.found;
         lut_in.range_mm = ang_ff.range_mm;
         lut_in.pos      = ang_ff.pos;
         // cosine runs one quadrant ahead of sine
         case (ang_ff.quad)
            2'd0: begin
               lut_in.sin_mag = sv; lut_in.sin_neg = 1'b0;
               lut_in.cos_mag = cv; lut_in.cos_neg = 1'b0;
            end
            2'd1: begin
               lut_in.sin_mag = cv; lut_in.sin_neg = 1'b0;
               lut_in.cos_mag = sv; lut_in.cos_neg = 1'b1;
            end
            2'd2: begin
               lut_in.sin_mag = sv; lut_in.sin_neg = 1'b1;
               lut_in.cos_mag = cv; lut_in.cos_neg = 1'b1;
            end
            default: begin
               lut_in.sin_mag = cv; lut_in.sin_neg = 1'b1;
               lut_in.cos_mag = sv; lut_in.cos_neg = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_vld_ff <= 1'b0;
         lut_vld_ff <= 1'b0;
      end else begin
         ang_vld_ff <= ang_vld_in;
         lut_vld_ff <= lut_vld_in;
      end
      ang_ff <= ang_in;
      lut_ff <= lut_in;
   end

   assign out_valid = lut_vld_ff;
   assign out_trig  = lut_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      ang_vld_ff |-> ang_ff.step < lno_pkg::STEP_W'(lno_pkg::QUARTER))
      else $error("angle step outside the quadrant");

endmodule

/* hw/rtl/lno_coord.sv */
// range times sine and cosine with rounding, into the result register
module lno_coord (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  lno_pkg::trig_type                   in_trig,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lno_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser
);

   localparam int PROD_W = lno_pkg::RANGE_W + lno_pkg::MAG_W;
   localparam int Q_W    = PROD_W + 1 - 15;
   localparam int PAD_W  = lno_pkg::RSP_DATA_W - 2 * lno_pkg::COORD_W - lno_pkg::POS_W;

   logic                                  vld_ff, vld_in;
   logic [lno_pkg::RSP_DATA_W-1:0]        data_ff, data_in;
   logic                                  found_ff, found_in;

   logic [PROD_W-1:0]                     x_prod;
   logic [PROD_W-1:0]                     y_prod;
   logic [PROD_W:0]                       x_sum;
   logic [PROD_W:0]                       y_sum;
   logic [Q_W-1:0]                        x_q;
   logic [Q_W-1:0]                        y_q;
   logic [lno_pkg::COORD_W-1:0]           x_mm;
   logic [lno_pkg::COORD_W-1:0]           y_mm;

   assign in_ready = !vld_ff || rsp_tready;

   // round half away from zero on the magnitude, then apply the sign
   assign x_prod = PROD_W'(in_trig.range_mm) * PROD_W'(in_trig.cos_mag);
   assign y_prod = PROD_W'(in_trig.range_mm) * PROD_W'(in_trig.sin_mag);
   assign x_sum = {1'b0, x_prod} + (PROD_W + 1)'(16384);
   assign y_sum = {1'b0, y_prod} + (PROD_W + 1)'(16384);
   assign x_q   = x_sum[PROD_W:15];
   assign y_q   = y_sum[PROD_W:15];
   assign x_mm  = in_trig.cos_neg ? (lno_pkg::COORD_W'(0) - lno_pkg::COORD_W'(x_q))
                                  : lno_pkg::COORD_W'(x_q);
   assign y_mm  = in_trig.sin_neg ? (lno_pkg::COORD_W'(0) - lno_pkg::COORD_W'(y_q))
                                  : lno_pkg::COORD_W'(y_q);

   always_comb begin
      vld_in   = in_ready ? in_valid : vld_ff;
      data_in  = data_ff;
      found_in = found_ff;
      if (in_valid && in_ready) begin
         found_in = in_trig.found;
         if (in_trig.found) begin
            data_in = {{PAD_W{1'b0}}, in_trig.pos, y_mm, x_mm};
         end else begin
            data_in = {{PAD_W{1'b0}}, {lno_pkg::POS_W{1'b0}},
                       lno_pkg::NOT_FOUND_MM, lno_pkg::NOT_FOUND_MM};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff  <= data_in;
      found_ff <= found_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = found_ff;

endmodule
